### hw/rtl/plsc_pkg.sv
// Shared types and constants for the pixel linear scale and clamp block.
// Used by every module in hw/rtl; depends on nothing.
package plsc_pkg;

    localparam int APB_ADDR_W = 6;
    localparam int APB_DATA_W = 64;

    localparam logic [2:0] REG_FORMAT      = 3'd0;
    localparam logic [2:0] REG_BLANK_EN    = 3'd1;
    localparam logic [2:0] REG_BLANK_VAL   = 3'd2;
    localparam logic [2:0] REG_SCALE       = 3'd3;
    localparam logic [2:0] REG_OFFSET      = 3'd4;
    localparam logic [2:0] REG_CLAMP_MIN   = 3'd5;
    localparam logic [2:0] REG_CLAMP_MAX   = 3'd6;
    localparam logic [2:0] REG_REPLACEMENT = 3'd7;

    localparam logic [2:0] FMT_UINT8   = 3'd0;
    localparam logic [2:0] FMT_INT16   = 3'd1;
    localparam logic [2:0] FMT_INT32   = 3'd2;
    localparam logic [2:0] FMT_FLOAT32 = 3'd3;
    localparam logic [2:0] FMT_FLOAT64 = 3'd4;

    localparam logic [7:0]  BYTE_MAX       = 8'd255;
    localparam logic [31:0] SCALE_RESET    = 32'h0001_0000;
    localparam logic [7:0]  F32_EXP_ONES   = 8'hFF;
    localparam logic [10:0] F64_EXP_ONES   = 11'h7FF;
    localparam logic [11:0] F32_SHIFT_BIAS = 12'd134;
    localparam logic [11:0] F64_SHIFT_BIAS = 12'd1059;
    localparam logic [11:0] F32_LEFT_MAX   = 12'd24;
    localparam logic [11:0] MANT_W         = 12'd53;
    localparam logic [47:0] Q_POS_MAG      = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] Q_NEG_MAG      = 48'h8000_0000_0000;

    typedef struct packed {
        logic [63:0] pixel_word;
        logic        last_in;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] pixel_out;
        logic       was_replaced;
        logic       last_out;
    } t_pix_out;

    typedef struct packed {
        logic [2:0]  fmt;
        logic        blank_en;
        logic [31:0] blank_val;
        logic [31:0] scale;
        logic [47:0] offset;
        logic [7:0]  clamp_min;
        logic [7:0]  clamp_max;
        logic [7:0]  replacement;
    } t_cfg;

    typedef struct packed {
        logic        is_float;
        logic        is_f64;
        logic        neg;
        logic [52:0] mant;
        logic [11:0] sh;
        logic [53:0] q_int;
        logic        repl;
        logic        last;
    } t_dec;

    typedef struct packed {
        logic [53:0] q;
        logic        repl;
        logic        last;
    } t_fix;

    typedef struct packed {
        logic [59:0] p_lo;
        logic [58:0] p_hi;
        logic        repl;
        logic        last;
    } t_prod;

    typedef struct packed {
        logic [86:0] s;
        logic        repl;
        logic        last;
    } t_sum;

endpackage

### hw/rtl/plsc_regs.sv
// APB configuration registers for the pixel linear scale and clamp block.
// Depends on plsc_pkg.
module plsc_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [plsc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [plsc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [plsc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output plsc_pkg::t_cfg                      o_cfg
);

    plsc_pkg::t_cfg r_cfg;
    logic [2:0]     idx;
    logic           wr;

    assign idx    = paddr[5:3];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fmt         <= plsc_pkg::FMT_UINT8;
            r_cfg.blank_en    <= 1'b0;
            r_cfg.blank_val   <= '0;
            r_cfg.scale       <= plsc_pkg::SCALE_RESET;
            r_cfg.offset      <= '0;
            r_cfg.clamp_min   <= '0;
            r_cfg.clamp_max   <= plsc_pkg::BYTE_MAX;
            r_cfg.replacement <= '0;
        end else if (wr) begin
            unique case (idx)
                plsc_pkg::REG_FORMAT:      r_cfg.fmt         <= pwdata[2:0];
                plsc_pkg::REG_BLANK_EN:    r_cfg.blank_en    <= pwdata[0];
                plsc_pkg::REG_BLANK_VAL:   r_cfg.blank_val   <= pwdata[31:0];
                plsc_pkg::REG_SCALE:       r_cfg.scale       <= pwdata[31:0];
                plsc_pkg::REG_OFFSET:      r_cfg.offset      <= pwdata[47:0];
                plsc_pkg::REG_CLAMP_MIN:   r_cfg.clamp_min   <= pwdata[7:0];
                plsc_pkg::REG_CLAMP_MAX:   r_cfg.clamp_max   <= pwdata[7:0];
                plsc_pkg::REG_REPLACEMENT: r_cfg.replacement <= pwdata[7:0];
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            plsc_pkg::REG_FORMAT:      prdata = {61'b0, r_cfg.fmt};
            plsc_pkg::REG_BLANK_EN:    prdata = {63'b0, r_cfg.blank_en};
            plsc_pkg::REG_BLANK_VAL:   prdata = {32'b0, r_cfg.blank_val};
            plsc_pkg::REG_SCALE:       prdata = {32'b0, r_cfg.scale};
            plsc_pkg::REG_OFFSET:      prdata = {16'b0, r_cfg.offset};
            plsc_pkg::REG_CLAMP_MIN:   prdata = {56'b0, r_cfg.clamp_min};
            plsc_pkg::REG_CLAMP_MAX:   prdata = {56'b0, r_cfg.clamp_max};
            plsc_pkg::REG_REPLACEMENT: prdata = {56'b0, r_cfg.replacement};
        endcase
    end

endmodule

### hw/rtl/plsc_decode.sv
// Two-stage pixel decode: format unpack and blank or non-finite test, then float to Q32.16 shift.
// Depends on plsc_pkg.
module plsc_decode (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  plsc_pkg::t_cfg    i_cfg,
    input  logic              i_valid,
    input  plsc_pkg::t_pix_in i_pixel,
    output logic              o_valid,
    output plsc_pkg::t_fix    o_fix
);

    plsc_pkg::t_dec r_dec, n_dec;
    plsc_pkg::t_fix r_fix, n_fix;
    logic           r_dec_vld;
    logic           r_fix_vld;

    logic [63:0] w;
    logic [7:0]  e8;
    logic [10:0] e11;

    assign w   = i_pixel.pixel_word;
    assign e8  = w[30:23];
    assign e11 = w[62:52];

    // unpack the word
    always_comb begin
        n_dec          = '0;
        n_dec.last     = i_pixel.last_in;
        unique case (i_cfg.fmt)
            plsc_pkg::FMT_UINT8: begin
                n_dec.repl  = i_cfg.blank_en && (w[7:0] == i_cfg.blank_val[7:0]);
                n_dec.q_int = {30'b0, w[7:0], 16'b0};
            end
            plsc_pkg::FMT_INT16: begin
                n_dec.repl  = i_cfg.blank_en && (w[15:0] == i_cfg.blank_val[15:0]);
                n_dec.q_int = {{22{w[15]}}, w[15:0], 16'b0};
            end
            plsc_pkg::FMT_INT32: begin
                n_dec.repl  = i_cfg.blank_en && (w[31:0] == i_cfg.blank_val);
                n_dec.q_int = {{6{w[31]}}, w[31:0], 16'b0};
            end
            plsc_pkg::FMT_FLOAT32: begin
                n_dec.is_float = 1'b1;
                n_dec.repl     = (e8 == plsc_pkg::F32_EXP_ONES);
                n_dec.neg      = w[31];
                n_dec.mant     = {29'b0, (e8 != 8'd0), w[22:0]};
                n_dec.sh       = ((e8 == 8'd0) ? 12'd1 : {4'b0, e8})
                                 - plsc_pkg::F32_SHIFT_BIAS;
            end
            plsc_pkg::FMT_FLOAT64: begin
                n_dec.is_float = 1'b1;
                n_dec.is_f64   = 1'b1;
                n_dec.repl     = (e11 == plsc_pkg::F64_EXP_ONES);
                n_dec.neg      = w[63];
                n_dec.mant     = {(e11 != 11'd0), w[51:0]};
                n_dec.sh       = ((e11 == 11'd0) ? 12'd1 : {1'b0, e11})
                                 - plsc_pkg::F64_SHIFT_BIAS;
            end
            default: begin
                n_dec.repl = 1'b1;
            end
        endcase
    end

    logic        left;
    logic [11:0] rsh;
    logic [47:0] mag48;
    logic        sat;
    logic [52:0] mag;
    logic [53:0] pos;

    // shift, saturate and sign the float magnitude, or pass the integer value
    always_comb begin
        left  = !r_dec.sh[11];
        rsh   = ~r_dec.sh + 12'd1;
        mag48 = {24'b0, r_dec.mant[23:0]} << r_dec.sh[4:0];
        sat   = 1'b0;
        mag   = '0;
        if (left) begin
            if (r_dec.is_f64 || (r_dec.sh > plsc_pkg::F32_LEFT_MAX)) begin
                sat = 1'b1;
            end else begin
                sat = r_dec.neg ? (mag48 > plsc_pkg::Q_NEG_MAG) : mag48[47];
            end
            if (sat) begin
                mag = {5'b0, r_dec.neg ? plsc_pkg::Q_NEG_MAG : plsc_pkg::Q_POS_MAG};
            end else begin
                mag = {5'b0, mag48};
            end
        end else if (rsh < plsc_pkg::MANT_W) begin
            mag = r_dec.mant >> rsh[5:0];
        end
        pos        = {1'b0, mag};
        n_fix.repl = r_dec.repl;
        n_fix.last = r_dec.last;
        if (r_dec.is_float) begin
            n_fix.q = r_dec.neg ? (~pos + 54'd1) : pos;
        end else begin
            n_fix.q = r_dec.q_int;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dec_vld <= 1'b0;
            r_fix_vld <= 1'b0;
        end else begin
            r_dec_vld <= i_valid;
            r_fix_vld <= r_dec_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dec <= n_dec;
        r_fix <= n_fix;
    end

    assign o_valid = r_fix_vld;
    assign o_fix   = r_fix;

endmodule

### hw/rtl/plsc_mac.sv
// Split multiply by the Q16.16 gain, then partial product sum plus Q32.16 offset.
// Depends on plsc_pkg.
module plsc_mac (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  plsc_pkg::t_cfg i_cfg,
    input  logic           i_valid,
    input  plsc_pkg::t_fix i_fix,
    output logic           o_valid,
    output plsc_pkg::t_sum o_sum
);

    plsc_pkg::t_prod r_prod, n_prod;
    plsc_pkg::t_sum  r_sum, n_sum;
    logic            r_prod_vld;
    logic            r_sum_vld;

    logic signed [59:0] p_lo;
    logic signed [58:0] p_hi;

    assign p_lo = $signed({1'b0, i_fix.q[26:0]}) * $signed(i_cfg.scale);
    assign p_hi = $signed(i_fix.q[53:27]) * $signed(i_cfg.scale);

    always_comb begin
        n_prod.p_lo = p_lo;
        n_prod.p_hi = p_hi;
        n_prod.repl = i_fix.repl;
        n_prod.last = i_fix.last;
    end

    always_comb begin
        n_sum.s    = {r_prod.p_hi[58], r_prod.p_hi, 27'b0}
                   + {{27{r_prod.p_lo[59]}}, r_prod.p_lo}
                   + {{23{i_cfg.offset[47]}}, i_cfg.offset, 16'b0};
        n_sum.repl = r_prod.repl;
        n_sum.last = r_prod.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
            r_sum_vld  <= 1'b0;
        end else begin
            r_prod_vld <= i_valid;
            r_sum_vld  <= r_prod_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_sum  <= n_sum;
    end

    assign o_valid = r_sum_vld;
    assign o_sum   = r_sum;

endmodule

### hw/rtl/plsc_clamp.sv
// Floor, window clamp and replacement select into the output register.
// Depends on plsc_pkg.
module plsc_clamp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  plsc_pkg::t_cfg     i_cfg,
    input  logic               i_valid,
    input  plsc_pkg::t_sum     i_sum,
    output logic               o_done,
    output plsc_pkg::t_pix_out o_result
);

    plsc_pkg::t_pix_out r_out, n_out;
    logic               r_done;

    logic       neg;
    logic       above;
    logic [7:0] t;

    assign neg   = i_sum.s[86];
    assign above = |i_sum.s[85:40];
    assign t     = i_sum.s[39:32];

    always_comb begin
        n_out.was_replaced = i_sum.repl;
        n_out.last_out     = i_sum.last;
        priority if (i_sum.repl) begin
            n_out.pixel_out = i_cfg.replacement;
        end else if (neg) begin
            n_out.pixel_out = i_cfg.clamp_min;
        end else if (above) begin
            n_out.pixel_out = i_cfg.clamp_max;
        end else if (t < i_cfg.clamp_min) begin
            n_out.pixel_out = i_cfg.clamp_min;
        end else if (t > i_cfg.clamp_max) begin
            n_out.pixel_out = i_cfg.clamp_max;
        end else begin
            n_out.pixel_out = t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_done   = r_done;
    assign o_result = r_out;

endmodule

### hw/rtl/pixel_linear_scale_clamp.sv
// Throughput: one word per cycle; five register stages (unpack, float shift,
// split multiply, offset sum, clamp) each take a new word every cycle.
// busy is held low: results are never stalled by the receiver.
// Reset (synchronous, active low) clears all stage valid bits and loads register defaults.
module pixel_linear_scale_clamp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  plsc_pkg::t_pix_in               i_pixel,
    output logic                            o_done,
    output plsc_pkg::t_pix_out              o_result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [plsc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [plsc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [plsc_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    plsc_pkg::t_cfg cfg;
    plsc_pkg::t_fix fix;
    plsc_pkg::t_sum sum;
    logic           fix_vld;
    logic           sum_vld;
    logic           accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    plsc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    plsc_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (accept),
        .i_pixel (i_pixel),
        .o_valid (fix_vld),
        .o_fix   (fix)
    );

    plsc_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (fix_vld),
        .i_fix   (fix),
        .o_valid (sum_vld),
        .o_sum   (sum)
    );

    plsc_clamp u_clamp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_valid  (sum_vld),
        .i_sum    (sum),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule

### hw/rtl/plsc_checker.sv
// Port-level checks for pixel_linear_scale_clamp, bound to the top level.
// Depends on plsc_pkg and pixel_linear_scale_clamp.
module plsc_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            start,
    input logic                            busy,
    input plsc_pkg::t_pix_in               i_pixel,
    input logic                            o_done,
    input plsc_pkg::t_pix_out              o_result,
    input logic                            psel,
    input logic                            penable,
    input logic                            pwrite,
    input logic [plsc_pkg::APB_ADDR_W-1:0] paddr,
    input logic [plsc_pkg::APB_DATA_W-1:0] pwdata,
    input logic [plsc_pkg::APB_DATA_W-1:0] prdata,
    input logic                            pready
);

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");

    a_word_out_per_word_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done == ($past(start && !busy, 5) && $past(i_rst_n, 1) && $past(i_rst_n, 2)
                   && $past(i_rst_n, 3) && $past(i_rst_n, 4) && $past(i_rst_n, 5)))
        else $error("result strobe does not match accepted word");

    a_last_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.last_out == $past(i_pixel.last_in, 5)))
        else $error("last_out does not match last_in");

endmodule

bind pixel_linear_scale_clamp plsc_checker u_plsc_checker (.*);
